[src/bc13_pkg.sv]
// shared types, constants and arithmetic helpers for the bc1/bc3 block decoder
`default_nettype none
package bc13_pkg;

    localparam int unsigned PIXELS   = 16;
    localparam int unsigned CNT_W    = $clog2(PIXELS);
    localparam int unsigned CIDX_W   = 2;
    localparam int unsigned AIDX_W   = 3;
    localparam int unsigned CHAN_W   = 8;
    localparam logic [7:0]  ALPHA_MAX = 8'd255;

    localparam logic [4:0] MASK5 = 5'h1F;
    localparam logic [5:0] MASK6 = 6'h3F;

    typedef enum logic {
        MODE_BC1 = 1'b0,
        MODE_BC3 = 1'b1
    } t_mode;

    typedef logic [3:0][CHAN_W-1:0] t_cpal;
    typedef logic [7:0][CHAN_W-1:0] t_apal;

    typedef struct packed {
        t_cpal                    red;
        t_cpal                    green;
        t_cpal                    blue;
        t_apal                    alpha;
        logic [PIXELS*CIDX_W-1:0] cidx;
        logic [PIXELS*AIDX_W-1:0] aidx;
    } t_blk;

    // rgb565 field widened to 8 bits by bit replication
    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v & MASK5, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v & MASK6, v[5:4]};
    endfunction

    // truncating divide by three via reciprocal, exact for x below 768
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] m;
        m = 21'(x) * 21'd683;
        return m[18:11];
    endfunction

    // truncating divide by seven, exact for x below 1792
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] m;
        m = 23'(x) * 23'd2341;
        return m[21:14];
    endfunction

    // truncating divide by five, exact for x below 1280
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] m;
        m = 23'(x) * 23'd3277;
        return m[21:14];
    endfunction

endpackage
`default_nettype wire

[src/bc1_bc3_texture_block_decoder_top.sv]
// top level of the bc1/bc3 texture block decoder
// One item is a compressed 4x4 block (64-bit colour half, 64-bit alpha half); it
// yields sixteen RGBA pixels in row-major order with row, column and a last flag
// on the sixteenth. A block is taken into an input register, its colour and
// alpha palettes are built by three colour lanes and an alpha lane in the cycle
// it moves on, and the pixel stage then emits one pixel per cycle unless i_ready
// stalls it. The single pixel output port limits the block rate; the next block
// is accepted while the current one is still being emitted. Pixels are read from
// the pixel stage's block register into output registers. format_mode (0 bc1,
// 1 bc3) is written through i_cfg_we / i_cfg_data and must only change while idle.
`default_nettype none
module bc1_bc3_texture_block_decoder_top
    import bc13_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_color_half,
    input  wire logic [63:0] i_alpha_half,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [1:0]       o_pixel_row,
    output logic [1:0]       o_pixel_col,
    output logic             o_last
);

    t_mode       r_mode;
    logic        a_valid;
    logic [63:0] a_ch;
    logic [63:0] a_ah;
    logic        load_ready;
    logic        four;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [7:0]  e0_r, e0_g, e0_b;
    logic [7:0]  e1_r, e1_g, e1_b;
    t_cpal       pal_r;
    t_cpal       pal_g;
    t_cpal       pal_b;
    t_apal       pal_a;
    t_blk        blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BC1;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    bc13_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_color_half (i_color_half),
        .i_alpha_half (i_alpha_half),
        .i_take       (load_ready),
        .o_valid      (a_valid),
        .o_color_half (a_ch),
        .o_alpha_half (a_ah)
    );

    always_comb begin
        c0   = a_ch[15:0];
        c1   = a_ch[31:16];
        four = (r_mode == MODE_BC3) || (c0 > c1);
        e0_r = widen5(c0[15:11]);
        e0_g = widen6(c0[10:5]);
        e0_b = widen5(c0[4:0]);
        e1_r = widen5(c1[15:11]);
        e1_g = widen6(c1[10:5]);
        e1_b = widen5(c1[4:0]);
        blk.red   = pal_r;
        blk.green = pal_g;
        blk.blue  = pal_b;
        blk.alpha = pal_a;
        blk.cidx  = a_ch[63:32];
        blk.aidx  = a_ah[63:16];
    end

    bc13_color_lane u_lane_r (.i_e0(e0_r), .i_e1(e1_r), .i_four(four), .o_pal(pal_r));
    bc13_color_lane u_lane_g (.i_e0(e0_g), .i_e1(e1_g), .i_four(four), .o_pal(pal_g));
    bc13_color_lane u_lane_b (.i_e0(e0_b), .i_e1(e1_b), .i_four(four), .o_pal(pal_b));

    bc13_alpha_lane u_lane_a (
        .i_a0   (a_ah[7:0]),
        .i_a1   (a_ah[15:8]),
        .i_mode (r_mode),
        .o_pal  (pal_a)
    );

    bc13_pixel_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (a_valid),
        .i_blk        (blk),
        .o_load_ready (load_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_pixel_row  (o_pixel_row),
        .o_pixel_col  (o_pixel_col),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

[src/bc13_color_lane.sv]
// one colour channel lane: four-entry palette from two widened endpoints
`default_nettype none
module bc13_color_lane
    import bc13_pkg::*;
(
    input  wire logic [7:0] i_e0,
    input  wire logic [7:0] i_e1,
    input  wire logic       i_four,
    output t_cpal           o_pal
);

    logic [9:0] s_near0;
    logic [9:0] s_near1;
    logic [8:0] s_mid;

    always_comb begin
        s_near0 = 10'({i_e0, 1'b0}) + 10'(i_e1);
        s_near1 = 10'(i_e0) + 10'({i_e1, 1'b0});
        s_mid   = 9'(i_e0) + 9'(i_e1);
        o_pal[0] = i_e0;
        o_pal[1] = i_e1;
        if (i_four) begin
            o_pal[2] = div3(s_near0);
            o_pal[3] = div3(s_near1);
        end else begin
            // three colours plus black
            o_pal[2] = s_mid[8:1];
            o_pal[3] = '0;
        end
    end

endmodule
`default_nettype wire

[src/bc13_alpha_lane.sv]
// alpha lane: eight-entry alpha palette, forced opaque in bc1 mode
`default_nettype none
module bc13_alpha_lane
    import bc13_pkg::*;
(
    input  wire logic [7:0] i_a0,
    input  wire logic [7:0] i_a1,
    input  wire t_mode      i_mode,
    output t_apal           o_pal
);

    always_comb begin
        logic [10:0] s7;
        logic [10:0] s5;
        o_pal[0] = i_a0;
        o_pal[1] = i_a1;
        for (int k = 1; k <= 6; k++) begin
            s7 = 11'(11'(7 - k) * 11'(i_a0)) + 11'(11'(k) * 11'(i_a1));
            s5 = 11'(11'(5 - k) * 11'(i_a0)) + 11'(11'(k) * 11'(i_a1));
            if (i_a0 > i_a1) begin
                o_pal[3'(k + 1)] = div7(s7);
            end else if (k <= 4) begin
                o_pal[3'(k + 1)] = div5(s5);
            end else if (k == 5) begin
                o_pal[3'(k + 1)] = '0;
            end else begin
                o_pal[3'(k + 1)] = ALPHA_MAX;
            end
        end
        if (i_mode == MODE_BC1) begin
            o_pal = {8{ALPHA_MAX}};
        end
    end

endmodule
`default_nettype wire

[src/bc13_pixel_merge.sv]
// merging stage: holds one block's palettes and emits its sixteen pixels
`default_nettype none
module bc13_pixel_merge
    import bc13_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_blk       i_blk,
    output logic            o_load_ready,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic [7:0]      o_alpha,
    output logic [1:0]      o_pixel_row,
    output logic [1:0]      o_pixel_col,
    output logic            o_last
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PIXELS - 1);

    t_blk             r_blk;
    logic             r_s_valid;
    logic [CNT_W-1:0] r_cnt;
    logic             r_o_valid;
    logic [7:0]       r_red, r_green, r_blue, r_alpha;
    logic [1:0]       r_row, r_col;
    logic             r_last;

    logic             out_adv;
    logic             emit;
    logic             last_emit;
    logic [1:0]       ci;
    logic [2:0]       ai;

    always_comb begin
        out_adv      = !r_o_valid || i_ready;
        emit         = r_s_valid && out_adv;
        last_emit    = emit && (r_cnt == CNT_LAST);
        o_load_ready = !r_s_valid || last_emit;
        ci           = r_blk.cidx[CIDX_W-1:0];
        ai           = r_blk.aidx[AIDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_load && o_load_ready) begin
                r_blk     <= i_blk;
                r_cnt     <= '0;
                r_s_valid <= 1'b1;
            end else if (emit) begin
                // index fields shift down so the current pixel sits at the bottom
                r_blk.cidx <= r_blk.cidx >> CIDX_W;
                r_blk.aidx <= r_blk.aidx >> AIDX_W;
                r_cnt      <= r_cnt + 1'b1;
                if (last_emit) begin
                    r_s_valid <= 1'b0;
                end
            end
            if (out_adv) begin
                r_o_valid <= r_s_valid;
            end
        end
        if (emit) begin
            r_red   <= r_blk.red[ci];
            r_green <= r_blk.green[ci];
            r_blue  <= r_blk.blue[ci];
            r_alpha <= r_blk.alpha[ai];
            r_row   <= r_cnt[CNT_W-1:CNT_W-2];
            r_col   <= r_cnt[1:0];
            r_last  <= (r_cnt == CNT_LAST);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_alpha     = r_alpha;
    assign o_pixel_row = r_row;
    assign o_pixel_col = r_col;
    assign o_last      = r_last;

endmodule
`default_nettype wire

[src/bc13_top_placeholder_unused.sv]
// per-block input register stage feeding the palette lanes
`default_nettype none
module bc13_in_stage
    import bc13_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_color_half,
    input  wire logic [63:0] i_alpha_half,
    input  wire logic        i_take,
    output logic             o_valid,
    output logic [63:0]      o_color_half,
    output logic [63:0]      o_alpha_half
);

    logic        r_valid;
    logic [63:0] r_ch;
    logic [63:0] r_ah;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_ch <= i_color_half;
            r_ah <= i_alpha_half;
        end
    end

    assign o_valid      = r_valid;
    assign o_color_half = r_ch;
    assign o_alpha_half = r_ah;

endmodule
`default_nettype wire

[tb/bc1_bc3_texture_block_decoder_top_tb.sv]
// self-checking testbench for the bc1/bc3 texture block decoder top level
`default_nettype none
module bc1_bc3_texture_block_decoder_top_tb;
    import bc13_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // alpha indices 0..7 twice over, low pixel first
    localparam logic [47:0] ALPHA_RAMP = 48'hFAC688_FAC688;
    localparam logic [31:0] COLOUR_RAMP = 32'hE4E4_E4E4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] row;
        logic [1:0] col;
        logic       last;
    } t_pixel;

    typedef struct {
        logic [63:0] color;
        logic [63:0] alpha;
        bit          wait_drained;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic [63:0] i_color_half = '0;
    logic [63:0] i_alpha_half = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [1:0]  o_pixel_row;
    logic [1:0]  o_pixel_col;
    logic        o_last;

    t_mode       format_sel = MODE_BC1;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          pixels_due = 0;
    int          pixels_done = 0;
    int          mismatches = 0;
    t_block      blocks_to_send[$];
    t_block      on_wire;
    t_pixel      expected_pixels[$];

    bc1_bc3_texture_block_decoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_color_half (i_color_half),
        .i_alpha_half (i_alpha_half),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_pixel_row  (o_pixel_row),
        .o_pixel_col  (o_pixel_col),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [23:0] expand565(input logic [15:0] v);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = v[15:11];
        g6 = v[10:5];
        b5 = v[4:0];
        return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
    endfunction

    // weighted blend with truncating divide
    function automatic logic [7:0] mix(input int unsigned x, input int unsigned y,
                                       input int unsigned wy, input int unsigned total);
        int unsigned s;
        s = (x * (total - wy) + y * wy) / total;
        return 8'(s);
    endfunction

    function automatic void decode_pixels(input t_mode mode, input logic [63:0] ch,
                                          input logic [63:0] ah);
        logic [23:0] ep [2];
        logic [7:0]  pal [4][3];
        logic [7:0]  apal [8];
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [1:0]  ci;
        logic [2:0]  ai;
        bit          four_colour;
        t_pixel      px;
        ep[0] = expand565(ch[15:0]);
        ep[1] = expand565(ch[31:16]);
        four_colour = (mode == MODE_BC3) || (ch[15:0] > ch[31:16]);
        for (int k = 0; k < 3; k++) begin
            pal[0][k] = ep[0][23-8*k -: 8];
            pal[1][k] = ep[1][23-8*k -: 8];
            if (four_colour) begin
                pal[2][k] = mix(pal[0][k], pal[1][k], 1, 3);
                pal[3][k] = mix(pal[0][k], pal[1][k], 2, 3);
            end else begin
                pal[2][k] = mix(pal[0][k], pal[1][k], 1, 2);
                pal[3][k] = 8'd0;
            end
        end
        a0 = ah[7:0];
        a1 = ah[15:8];
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1) begin
            for (int k = 1; k <= 6; k++) apal[1+k] = mix(a0, a1, k, 7);
        end else begin
            for (int k = 1; k <= 4; k++) apal[1+k] = mix(a0, a1, k, 5);
            apal[6] = 8'd0;
            apal[7] = 8'd255;
        end
        for (int p = 0; p < 16; p++) begin
            ci = ch[32+2*p +: 2];
            ai = ah[16+3*p +: 3];
            px.red   = pal[ci][0];
            px.green = pal[ci][1];
            px.blue  = pal[ci][2];
            px.alpha = (mode == MODE_BC3) ? apal[ai] : 8'd255;
            px.row   = 2'(p / 4);
            px.col   = 2'(p % 4);
            px.last  = (p == 15);
            expected_pixels.push_back(px);
        end
    endfunction

    task automatic compare_channel(input string name, input logic [7:0] got,
                                   input logic [7:0] want, input t_pixel ref_px);
        if (got !== want) begin
            $display("%0t: pixel r%0d c%0d %s expected %0d got %0d",
                     $time, ref_px.row, ref_px.col, name, want, got);
            mismatches++;
        end
    endtask

    // driver: presents queued blocks, predicts the pixels of each accepted one
    always @(posedge i_clk) begin
        bit accepted;
        accepted = i_valid && o_ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (accepted) begin
                decode_pixels(format_sel, on_wire.color, on_wire.alpha);
                pixels_due <= pixels_due + 16;
            end
            if (i_valid && !accepted) begin
                // hold the item until taken
            end else if (blocks_to_send.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct &&
                         !(blocks_to_send[0].wait_drained &&
                           (accepted || pixels_due != pixels_done))) begin
                on_wire = blocks_to_send.pop_front();
                i_valid      <= 1'b1;
                i_color_half <= on_wire.color;
                i_alpha_half <= on_wire.alpha;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure and pixel checks
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel r%0d c%0d rgba %0d %0d %0d %0d",
                             $time, o_pixel_row, o_pixel_col, o_red, o_green, o_blue,
                             o_alpha);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    compare_channel("red", o_red, want.red, want);
                    compare_channel("green", o_green, want.green, want);
                    compare_channel("blue", o_blue, want.blue, want);
                    compare_channel("alpha", o_alpha, want.alpha, want);
                    compare_channel("row", 8'(o_pixel_row), 8'(want.row), want);
                    compare_channel("col", 8'(o_pixel_col), 8'(want.col), want);
                    compare_channel("last", 8'(o_last), 8'(want.last), want);
                    pixels_done <= pixels_done + 1;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_block(input logic [63:0] color, input logic [63:0] alpha,
                               input bit wait_drained = 1'b0);
        t_block b;
        b.color = color;
        b.alpha = alpha;
        b.wait_drained = wait_drained;
        blocks_to_send.push_back(b);
    endtask

    // mode change only while nothing is in flight
    task automatic set_up(input t_mode mode, input int send_pct, input int stall_pct);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        format_sel = mode;
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (blocks_to_send.size() != 0 || i_valid || pixels_due != pixels_done);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_phase(input t_mode mode, input int send_pct, input int stall_pct,
                                input int count);
        logic [63:0] ch;
        logic [63:0] ah;
        set_up(mode, send_pct, stall_pct);
        for (int n = 0; n < count; n++) begin
            ch = {$urandom, $urandom};
            ah = {$urandom, $urandom};
            case ($urandom_range(5))
                0: ch[31:16] = ch[15:0];
                1: ah[15:8] = ah[7:0];
                2: begin
                    ch[31:16] = ch[15:0] + 16'd1;
                    ah[15:8]  = ah[7:0] - 8'd1;
                end
                default: ;
            endcase
            queue_block(ch, ah, n == 14);
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_up(MODE_BC1, 0, 0);
        queue_block('0, '0);
        queue_block('1, '1);
        queue_block({COLOUR_RAMP, 16'h0000, 16'hFFFF}, '1);
        queue_block({COLOUR_RAMP, 16'hFFFF, 16'h0000}, '0);
        // endpoints one apart with c0 above c1, just on the four-colour side of the switch
        queue_block({COLOUR_RAMP, 16'h0000, 16'h0001}, '0);
        queue_block({32'h1B1B_1B1B, 16'h07E0, 16'hF800}, '0);
        queue_block({COLOUR_RAMP, 16'hF81F, 16'h001F}, '0);
        queue_block({COLOUR_RAMP, 16'h8410, 16'h8410}, {$urandom, $urandom});
        drain();

        set_up(MODE_BC3, 0, 0);
        queue_block('0, '0);
        queue_block('1, '1);
        queue_block({COLOUR_RAMP, 16'hFFFF, 16'h0000}, {ALPHA_RAMP, 8'h00, 8'hFF});
        queue_block({COLOUR_RAMP, 16'h0000, 16'hFFFF}, {ALPHA_RAMP, 8'hFF, 8'h00});
        queue_block({COLOUR_RAMP, 16'h1234, 16'hABCD}, {ALPHA_RAMP, 8'h80, 8'h80});
        queue_block({COLOUR_RAMP, 16'h0001, 16'h0000}, {ALPHA_RAMP, 8'h40, 8'h41});
        queue_block({COLOUR_RAMP, 16'h0000, 16'hFFFF}, {ALPHA_RAMP, 8'h00, 8'h01});
        queue_block({32'h1B1B_1B1B, 16'h07E0, 16'hF800}, {ALPHA_RAMP, 8'h01, 8'h00});
        queue_block({COLOUR_RAMP, 16'h8410, 16'h8410}, {ALPHA_RAMP, 8'hC3, 8'h5A});
        drain();

        random_phase(MODE_BC1, 0, 0, 26);
        random_phase(MODE_BC3, 80, 0, 26);
        random_phase(MODE_BC1, 0, 80, 26);
        random_phase(MODE_BC3, 12, 12, 26);
        random_phase(MODE_BC3, 0, 0, 26);
        random_phase(MODE_BC1, 12, 12, 26);

        repeat (20) @(negedge i_clk);
        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d pixels never arrived", $time, expected_pixels.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("%0t: timed out", $time);
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
src/bc13_pkg.sv
src/bc13_color_lane.sv
src/bc13_alpha_lane.sv
src/bc13_pixel_merge.sv
src/bc13_top_placeholder_unused.sv
src/bc1_bc3_texture_block_decoder_top.sv
tb/bc1_bc3_texture_block_decoder_top_tb.sv
